FILE: src/shnl_pkg.sv
`default_nettype none

package shnl_pkg;

  localparam int NOTE_SLOTS_DEF = 16;
  localparam int NOTE_W = 7;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_REMOVED   = 3'd1,
    STAT_DUPLICATE = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [NOTE_W-1:0] pitch;
  } cell_cmd_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic              occ;
    logic              lt;
    logic              mark;
    logic [NOTE_W-1:0] note;
  } link_t;

endpackage

`default_nettype wire

FILE: src/shnl_cell.sv
`default_nettype none

module shnl_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire shnl_pkg::cell_cmd_t   cmd,
  input  wire shnl_pkg::link_t       prev,
  input  wire shnl_pkg::link_t       next,
  output shnl_pkg::link_t            link,
  output logic                       eq
);

  logic [shnl_pkg::NOTE_W-1:0] note;
  logic                        occ;
  logic                        mark;
  logic                        lt;
  logic                        take_next;

  assign lt        = occ && (note < cmd.pitch);
  assign eq        = occ && (note == cmd.pitch);
  assign take_next = cmd.remove && occ && !lt;

  assign link.occ  = occ;
  assign link.lt   = lt;
  assign link.mark = mark;
  assign link.note = note;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= 1'b0;
      mark <= 1'b0;
    end else if (cmd.insert) begin
      if (!lt) begin
        // first cell not below the pitch takes it, the rest shift up
        if (prev.lt) begin
          occ  <= 1'b1;
          mark <= 1'b1;
        end else begin
          occ  <= prev.occ;
          mark <= 1'b0;
        end
      end else begin
        mark <= 1'b0;
      end
    end else if (take_next) begin
      occ  <= next.occ;
      mark <= next.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !lt) begin
      note <= prev.lt ? cmd.pitch : prev.note;
    end else if (take_next) begin
      note <= next.note;
    end
  end

endmodule

`default_nettype wire

FILE: src/shnl_report.sv
`default_nettype none

module shnl_report #(
  parameter int NOTE_SLOTS = shnl_pkg::NOTE_SLOTS_DEF,
  localparam int IDX_W = $clog2(NOTE_SLOTS)
) (
  input  wire  [shnl_pkg::NOTE_W-1:0] notes [NOTE_SLOTS],
  input  wire  [NOTE_SLOTS-1:0]       occ,
  input  wire  [NOTE_SLOTS-1:0]       mark,
  output logic [shnl_pkg::NOTE_W-1:0] lowest_note,
  output logic [shnl_pkg::NOTE_W-1:0] highest_note,
  output logic                        last_valid,
  output logic [shnl_pkg::NOTE_W-1:0] last_note,
  output logic [IDX_W-1:0]            last_index
);

  logic [NOTE_SLOTS-1:0] top;

  // the top occupied cell is the one whose upper neighbor is empty
  assign top = occ & ~(occ >> 1);

  assign lowest_note = occ[0] ? notes[0] : '0;
  assign last_valid  = |mark;

  always_comb begin
    highest_note = '0;
    last_note    = '0;
    last_index   = '0;
    for (int i = 0; i < NOTE_SLOTS; i++) begin
      if (top[i]) begin
        highest_note = highest_note | notes[i];
      end
      if (mark[i]) begin
        last_note  = last_note | notes[i];
        last_index = last_index | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/sorted_held_note_list.sv
// Held-note list kept sorted by ascending pitch in a row of NOTE_SLOTS cells,
// each cell holding one pitch, an occupied bit and the last-struck mark. A
// transfer with s_tuser = 0 inserts the pitch (ignored if already held or the
// list is full), s_tuser = 1 removes it and closes the gap. Every event gives
// exactly one result with a status, the count, lowest and highest pitch and
// the last-struck pitch and position; missing values read as zero. On the
// accept edge all cells compare against the pitch and shift in parallel, and
// in the load state that follows, the row is gathered into the output
// register. A result waiting at the output blocks only the gathering step;
// the next event is taken once the result register is loaded.
`default_nettype none

module sorted_held_note_list #(
  parameter int NOTE_SLOTS = shnl_pkg::NOTE_SLOTS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,  // note_number[6:0], zero pad
  input  wire         s_tuser,  // mode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,  // held_count[4:0], lowest_note[11:5],
                                // highest_note[18:12], last_valid[19],
                                // last_note[26:20], last_index[30:27], zero pad
  output logic [2:0]  m_tuser   // status
);

  localparam int CNT_W = $clog2(NOTE_SLOTS + 1);
  localparam int IDX_W = $clog2(NOTE_SLOTS);
  localparam int NW    = shnl_pkg::NOTE_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  shnl_pkg::status_t     status;
  shnl_pkg::status_t     status_next;

  shnl_pkg::cell_cmd_t   cmd;
  shnl_pkg::link_t       links     [NOTE_SLOTS];
  shnl_pkg::link_t       prev_link [NOTE_SLOTS];
  shnl_pkg::link_t       next_link [NOTE_SLOTS];
  logic [NOTE_SLOTS-1:0] eq_vec;
  logic [NOTE_SLOTS-1:0] occ_vec;
  logic [NOTE_SLOTS-1:0] mark_vec;
  logic [NW-1:0]         notes [NOTE_SLOTS];

  logic                  accept;
  logic                  found;
  logic                  full;
  logic                  load_out;

  logic [NW-1:0]         lowest_note;
  logic [NW-1:0]         highest_note;
  logic                  last_valid;
  logic [NW-1:0]         last_note;
  logic [IDX_W-1:0]      last_index;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign found    = |eq_vec;
  assign full     = (count == CNT_W'(NOTE_SLOTS));
  assign load_out = (state == S_LOAD) && (!m_tvalid || m_tready);

  assign cmd.pitch  = s_tdata[NW-1:0];
  assign cmd.insert = accept && !s_tuser && !full && !found;
  assign cmd.remove = accept && s_tuser && found;

  for (genvar i = 0; i < NOTE_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_link[i] = '{occ: 1'b1, lt: 1'b1, mark: 1'b0, note: '0};
    end else begin : g_mid_prev
      assign prev_link[i] = links[i-1];
    end
    if (i == NOTE_SLOTS - 1) begin : g_tail
      assign next_link[i] = '{occ: 1'b0, lt: 1'b0, mark: 1'b0, note: '0};
    end else begin : g_mid_next
      assign next_link[i] = links[i+1];
    end

    shnl_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .prev (prev_link[i]),
      .next (next_link[i]),
      .link (links[i]),
      .eq   (eq_vec[i])
    );

    assign occ_vec[i]  = links[i].occ;
    assign mark_vec[i] = links[i].mark;
    assign notes[i]    = links[i].note;
  end

  shnl_report #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_report (
    .notes        (notes),
    .occ          (occ_vec),
    .mark         (mark_vec),
    .lowest_note  (lowest_note),
    .highest_note (highest_note),
    .last_valid   (last_valid),
    .last_note    (last_note),
    .last_index   (last_index)
  );

  always_comb begin
    count_next  = count;
    status_next = status;
    if (accept) begin
      priority if (!s_tuser && full) begin
        status_next = shnl_pkg::STAT_FULL;
      end else if (!s_tuser && found) begin
        status_next = shnl_pkg::STAT_DUPLICATE;
      end else if (!s_tuser) begin
        status_next = shnl_pkg::STAT_INSERTED;
        count_next  = count + CNT_W'(1);
      end else if (found) begin
        status_next = shnl_pkg::STAT_REMOVED;
        count_next  = count - CNT_W'(1);
      end else begin
        status_next = shnl_pkg::STAT_NOT_FOUND;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= status;
      m_tdata <= {1'b0, 4'(last_index), last_note, last_valid,
                  highest_note, lowest_note, 5'(count)};
    end
  end

  // count and the occupied prefix of the row move together
  assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == 32'(count))
    else $error("cell occupancy disagrees with note count");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NOTE_SLOTS))
    else $error("note count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0(mark_vec))
    else $error("more than one last-struck mark");

  // a result only appears after the gathering cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_LOAD))
    else $error("result raised outside the load step");

endmodule

`default_nettype wire

FILE: sim/tb_sorted_held_note_list.sv
`timescale 1ns / 1ps

module tb_sorted_held_note_list;

  localparam int SLOTS = shnl_pkg::NOTE_SLOTS_DEF;
  localparam bit NOTE_ON = 1'b0;
  localparam bit NOTE_OFF = 1'b1;
  localparam int RANDOM_EVENTS = 850;
  localparam int CHUNK = 50;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    shnl_pkg::status_t status;
    logic [4:0] count;
    logic [6:0] lowest;
    logic [6:0] highest;
    logic       mark_valid;
    logic [6:0] mark_note;
    logic [3:0] mark_index;
  } held_note_view;

  class held_note_board;
    logic [6:0] pitches [SLOTS];
    int held;
    bit mark_ok;
    int mark_pos;
    held_note_view expected_q[$];
    int errors;
    int results;
    int seen [5];
    int peak;

    function new();
      held = 0;
      mark_ok = 0;
      mark_pos = 0;
      errors = 0;
      results = 0;
      peak = 0;
      foreach (seen[i]) seen[i] = 0;
      foreach (pitches[i]) pitches[i] = '0;
    endfunction

    function shnl_pkg::status_t insert_note(logic [6:0] p);
      int pos;
      pos = 0;
      if (held >= SLOTS) return shnl_pkg::STAT_FULL;
      while (pos < held && pitches[pos] < p) pos++;
      if (pos < held && pitches[pos] == p) return shnl_pkg::STAT_DUPLICATE;
      for (int k = held; k > pos; k--) pitches[k] = pitches[k-1];
      pitches[pos] = p;
      held++;
      mark_pos = pos;
      mark_ok = 1;
      return shnl_pkg::STAT_INSERTED;
    endfunction

    function shnl_pkg::status_t remove_note(logic [6:0] p);
      int pos;
      pos = 0;
      while (pos < held && pitches[pos] != p) pos++;
      if (pos >= held) return shnl_pkg::STAT_NOT_FOUND;
      if (mark_ok && mark_pos == pos) mark_ok = 0;
      for (int k = pos; k + 1 < held; k++) pitches[k] = pitches[k+1];
      held--;
      // the mark slides down with the notes above the gap
      if (mark_ok && mark_pos > pos) mark_pos--;
      return shnl_pkg::STAT_REMOVED;
    endfunction

    function void note_event(bit off, logic [6:0] p);
      held_note_view v;
      v.status = off ? remove_note(p) : insert_note(p);
      v.count = held[4:0];
      v.lowest = (held > 0) ? pitches[0] : 7'd0;
      v.highest = (held > 0) ? pitches[held-1] : 7'd0;
      v.mark_valid = mark_ok;
      v.mark_note = mark_ok ? pitches[mark_pos] : 7'd0;
      v.mark_index = mark_ok ? mark_pos[3:0] : 4'd0;
      seen[v.status]++;
      if (held > peak) peak = held;
      expected_q.push_back(v);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] d);
      held_note_view e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("error: unexpected result st=%0d data=%h", st, d);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || d[4:0] !== e.count || d[11:5] !== e.lowest ||
          d[18:12] !== e.highest || d[19] !== e.mark_valid ||
          d[26:20] !== e.mark_note || d[30:27] !== e.mark_index) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp st=%0d cnt=%0d lo=%0d hi=%0d lv=%0d ln=%0d li=%0d",
                   e.status, e.count, e.lowest, e.highest, e.mark_valid,
                   e.mark_note, e.mark_index);
          $display("          got st=%0d cnt=%0d lo=%0d hi=%0d lv=%0d ln=%0d li=%0d",
                   st, d[4:0], d[11:5], d[18:12], d[19], d[26:20], d[30:27]);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  bit src_idle;
  bit snk_idle;
  int cycles;
  held_note_board sb;

  sorted_held_note_list #(.NOTE_SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // transfers on both sides, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_event(s_tuser, s_tdata[6:0]);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
  end

  // result side back-pressure
  initial begin
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (snk_idle && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_note(input bit off, input logic [6:0] p);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= off;
    s_tdata <= {1'b0, p};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // steer the list toward a fill level, removing mostly notes that are held
  task automatic pick_event(input int level, output bit off, output logic [6:0] p);
    int r;
    bit want_on;
    r = $urandom_range(0, 99);
    if (sb.held < level) want_on = (r < 80);
    else if (sb.held > level) want_on = (r < 20);
    else want_on = (r < 50);
    off = want_on ? NOTE_ON : NOTE_OFF;
    r = $urandom_range(0, 99);
    if (sb.held > 0 && ((off == NOTE_OFF && r < 75) || (off == NOTE_ON && r < 12)))
      p = sb.pitches[$urandom_range(0, sb.held - 1)];
    else if (r < 92)
      p = 7'($urandom_range(0, 127));
    else
      p = r[0] ? 7'd127 : 7'd0;
  endtask

  initial begin
    bit off;
    logic [6:0] p;
    int level;
    int perm;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty list, extremes, duplicate, mark moves and clears
    send_note(NOTE_OFF, 7'd64);
    send_note(NOTE_ON, 7'd127);
    send_note(NOTE_ON, 7'd0);
    send_note(NOTE_ON, 7'd0);
    send_note(NOTE_ON, 7'd64);
    send_note(NOTE_OFF, 7'd0);
    send_note(NOTE_OFF, 7'd64);
    send_note(NOTE_OFF, 7'd127);
    // fill every slot in scrambled order, then knock on a full list
    for (int i = 0; i < SLOTS; i++) begin
      perm = (i * 5) % SLOTS;
      send_note(NOTE_ON, 7'(perm * 8 + perm / 2));
    end
    send_note(NOTE_ON, 7'd5);
    send_note(NOTE_ON, 7'd0);

    level = SLOTS;
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % CHUNK == 0) begin
        if (n >= RANDOM_EVENTS - 3 * CHUNK) begin
          src_idle = 1'b0;
          snk_idle = 1'b0;
        end else begin
          src_idle = $urandom_range(0, 1);
          snk_idle = $urandom_range(0, 1);
        end
      end
      if (n % 30 == 0) level = $urandom_range(0, SLOTS);
      pick_event(level, off, p);
      send_note(off, p);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("events: %0d inserted, %0d removed, %0d duplicate, %0d full, %0d not found",
             sb.seen[shnl_pkg::STAT_INSERTED], sb.seen[shnl_pkg::STAT_REMOVED],
             sb.seen[shnl_pkg::STAT_DUPLICATE], sb.seen[shnl_pkg::STAT_FULL],
             sb.seen[shnl_pkg::STAT_NOT_FOUND]);
    $display("results checked: %0d, peak held notes: %0d, errors: %0d",
             sb.results, sb.peak, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sorted_held_note_list.f
src/shnl_pkg.sv
src/shnl_cell.sv
src/shnl_report.sv
src/sorted_held_note_list.sv
sim/tb_sorted_held_note_list.sv
